/* rtl/core/conv2d_7x7_scaled_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 7x7 convolution unit
// Short forms for clocked checks with a reset guard.
// ----------------------------------------------------------------------------
`ifndef CONV2D_7X7_SCALED_UNIT_MACROS_SVH
`define CONV2D_7X7_SCALED_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C2D_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2d check failed");

// The consequent must hold in the cycle after the antecedent.
`define C2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2d check failed");

`endif

/* rtl/core/c2d_pkg.sv */
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared widths, codes and types of the 7x7 convolution unit.
// ----------------------------------------------------------------------------
package c2d_pkg;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int KERNEL_W      = 7;
    localparam int TAPS          = KERNEL_W * KERNEL_W;
    localparam int LINES         = KERNEL_W - 1;
    localparam int TAP_IDX_W     = $clog2(TAPS);

    localparam int COL_W   = 9;
    localparam int SIZE_W  = 8;
    localparam int PIX_W   = 16;
    localparam int COEF_W  = 16;
    localparam int SCALE_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W   = 38;
    localparam int PROD_W  = ACC_W + COEF_W;
    localparam int RES_W   = 32;
    localparam int FRAC_SHIFT = 24;
    localparam int WIDE_W  = 64;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_COEF  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd2;

    localparam int SCALE_STEP = TAPS + 2;
    localparam int LAST_STEP  = TAPS + 3;
    localparam int STEP_W     = $clog2(LAST_STEP + 1);

    typedef struct packed {
        logic valid;
        logic first;
        logic scale;
    } mac_ctl_t;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             sat;
    } mac_res_t;

endpackage

/* rtl/core/c2d_mac.sv */
// ----------------------------------------------------------------------------
// c2d_mac
// Shared multiply-accumulate unit: taps accumulate, a scale step rounds and
// saturates the product of the sum and the scale.
// ----------------------------------------------------------------------------
module c2d_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  c2d_pkg::mac_ctl_t                    ctl,
    input  logic signed [c2d_pkg::ACC_W-1:0]     op_a,
    input  logic signed [c2d_pkg::COEF_W-1:0]    op_b,
    output logic signed [c2d_pkg::ACC_W-1:0]     acc,
    output c2d_pkg::mac_res_t                    res
);

    localparam logic signed [c2d_pkg::PROD_W-1:0] RND_HALF =
        c2d_pkg::PROD_W'(64'd1 << (c2d_pkg::FRAC_SHIFT - 1));
    localparam logic signed [c2d_pkg::WIDE_W-1:0] WIDE_MAX =
        c2d_pkg::WIDE_W'(signed'(c2d_pkg::RES_MAX));
    localparam logic signed [c2d_pkg::WIDE_W-1:0] WIDE_MIN =
        {{(c2d_pkg::WIDE_W-c2d_pkg::RES_W){1'b1}}, c2d_pkg::RES_MIN};

    c2d_pkg::mac_ctl_t                    ctl1_reg;
    logic signed [c2d_pkg::PROD_W-1:0]    prod_reg;
    logic signed [c2d_pkg::ACC_W-1:0]     acc_reg;
    logic signed [c2d_pkg::ACC_W-1:0]     acc_next;
    c2d_pkg::mac_res_t                    res_reg;
    c2d_pkg::mac_res_t                    res_next;
    logic signed [c2d_pkg::PROD_W-1:0]    rnd;
    logic signed [c2d_pkg::PROD_W-1:0]    quo;
    logic signed [c2d_pkg::WIDE_W-1:0]    quo_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        rnd      = prod_reg + RND_HALF;
        quo      = rnd >>> c2d_pkg::FRAC_SHIFT;
        quo_wide = {{(c2d_pkg::WIDE_W-c2d_pkg::PROD_W){quo[c2d_pkg::PROD_W-1]}}, quo};
        acc_next = acc_reg;
        res_next = res_reg;
        if (ctl1_reg.valid && !ctl1_reg.scale)
        begin
            acc_next = (ctl1_reg.first ? '0 : acc_reg) + prod_reg[c2d_pkg::ACC_W-1:0];
        end
        if (ctl1_reg.valid && ctl1_reg.scale)
        begin
            if (quo_wide > WIDE_MAX)
            begin
                res_next.value = c2d_pkg::RES_MAX;
                res_next.sat   = 1'b1;
            end
            else if (quo_wide < WIDE_MIN)
            begin
                res_next.value = c2d_pkg::RES_MIN;
                res_next.sat   = 1'b1;
            end
            else
            begin
                res_next.value = quo_wide[c2d_pkg::RES_W-1:0];
                res_next.sat   = 1'b0;
            end
        end
    end

    assign acc = acc_reg;
    assign res = res_reg;

endmodule

/* rtl/core/conv2d_7x7_scaled_unit.sv */
// ----------------------------------------------------------------------------
// conv2d_7x7_scaled_unit
// Streaming 7x7 valid convolution of a row-major image with a final scale.
// ----------------------------------------------------------------------------
// Input beats on the s_ group carry either a kernel coefficient load
// (s_tuser high) or one image pixel (s_tuser low). Result beats on the m_
// group carry the rounded, saturated, scaled window sum, with s_tuser's
// counterpart m_tuser flagging clipping and m_tlast marking a frame's last.
// Configuration writes on cfg_we set row width, output size and scale; the
// user must make them only while the block is idle, which the block itself
// does not enforce. A coefficient load or a pixel outside the used region
// leaves the block ready. A pixel inside the region first writes the line
// buffer, and one that completes a window then runs 49 taps through the one
// shared multiplier, the pipeline drain, the scale multiply and the hand-off
// to the output register before the block is ready again.
// The result waits in an output register; if the receiver stalls while a new
// result is ready, the block holds that result and is not ready until the
// register frees. Reset clears the counters and restores the register
// defaults; kernel and line buffer contents are undefined until written.
// ----------------------------------------------------------------------------
module conv2d_7x7_scaled_unit #(
    parameter int MAX_WIDTH = c2d_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // coef_index [5:0], coefficient [21:6], pixel [37:22], zero [39:38]
    input  logic [c2d_pkg::IN_DATA_W-1:0]      s_tdata,
    // mode [0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result [31:0]
    output logic [c2d_pkg::OUT_DATA_W-1:0]     m_tdata,
    // saturated [0]
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [c2d_pkg::CFG_W-1:0]          cfg_data
);

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int LINE_W  = c2d_pkg::LINES * c2d_pkg::PIX_W;
    localparam int COL_MAX = (1 << c2d_pkg::COL_W) - 1;
    localparam int USED_CAP = (MAX_WIDTH < COL_MAX) ? MAX_WIDTH : COL_MAX;
    localparam logic [c2d_pkg::COL_W-1:0] USED_CAP_V = c2d_pkg::COL_W'(USED_CAP);
    localparam logic [c2d_pkg::COL_W-1:0] LINES_V    = c2d_pkg::COL_W'(c2d_pkg::LINES);
    localparam logic [c2d_pkg::STEP_W-1:0] TAPS_V    = c2d_pkg::STEP_W'(c2d_pkg::TAPS);
    localparam logic [c2d_pkg::STEP_W-1:0] SCALE_V   = c2d_pkg::STEP_W'(c2d_pkg::SCALE_STEP);
    localparam logic [c2d_pkg::STEP_W-1:0] LAST_V    = c2d_pkg::STEP_W'(c2d_pkg::LAST_STEP);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [c2d_pkg::COL_W-1:0]          row_width_reg;
    logic [c2d_pkg::SIZE_W-1:0]         output_size_reg;
    logic signed [c2d_pkg::SCALE_W-1:0] scale_reg;

    logic [c2d_pkg::COL_W-1:0]  column_count_reg, column_count_next;
    logic [c2d_pkg::COL_W-1:0]  row_count_reg, row_count_next;
    logic [1:0]                 state_reg, state_next;
    logic [c2d_pkg::STEP_W-1:0] step_reg, step_next;

    logic signed [c2d_pkg::PIX_W-1:0]  pix_reg;
    logic [AW-1:0]                     waddr_reg;
    logic                              last_reg;
    logic                              produce_reg;
    logic [LINE_W-1:0]                 line_q_reg;
    logic [LINE_W-1:0]                 line_wdata;
    logic [LINE_W-1:0]                 row_mem [MAX_WIDTH];
    logic signed [c2d_pkg::COEF_W-1:0] coef_mem [c2d_pkg::TAPS];
    logic signed [c2d_pkg::COEF_W-1:0] coef_q_reg;
    logic signed [c2d_pkg::PIX_W-1:0]  win_reg [c2d_pkg::TAPS];
    logic signed [c2d_pkg::PIX_W-1:0]  win_head_reg;
    logic signed [c2d_pkg::PIX_W-1:0]  col_in [c2d_pkg::KERNEL_W];
    logic                              tap_valid_reg;
    logic                              tap_first_reg;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic [c2d_pkg::OUT_DATA_W-1:0]    m_tdata_reg;
    logic                              m_tuser_reg;
    logic                              m_tlast_reg;

    logic                              in_mode;
    logic [c2d_pkg::TAP_IDX_W-1:0]     in_index;
    logic signed [c2d_pkg::COEF_W-1:0] in_coef;
    logic signed [c2d_pkg::PIX_W-1:0]  in_pixel;
    logic                              accept;
    logic                              pix_accept;
    logic                              coef_write;
    logic [c2d_pkg::COL_W-1:0]         used;
    logic [c2d_pkg::COL_W-1:0]         used_m6;
    logic [c2d_pkg::COL_W-1:0]         cols;
    logic [c2d_pkg::COL_W:0]           cols_p6;
    logic [c2d_pkg::COL_W-1:0]         frame_rows;
    logic [c2d_pkg::COL_W:0]           col_inc;
    logic [c2d_pkg::COL_W:0]           row_inc;
    logic                              in_region;
    logic                              produce_now;
    logic                              last_now;
    logic                              tap_issue;
    logic                              scale_go;
    logic                              out_free;
    logic                              load_out;

    c2d_pkg::mac_ctl_t                    mac_ctl;
    logic signed [c2d_pkg::ACC_W-1:0]     mac_a;
    logic signed [c2d_pkg::COEF_W-1:0]    mac_b;
    logic signed [c2d_pkg::ACC_W-1:0]     mac_acc;
    c2d_pkg::mac_res_t                    mac_res;

    assign in_index = s_tdata[5:0];
    assign in_coef  = s_tdata[21:6];
    assign in_pixel = s_tdata[37:22];
    assign in_mode  = s_tuser;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign pix_accept = accept && (in_mode == c2d_pkg::MODE_PIXEL);
    assign coef_write = accept && (in_mode == c2d_pkg::MODE_COEF)
                        && (in_index < c2d_pkg::TAP_IDX_W'(c2d_pkg::TAPS));

    always_comb
    begin
        used    = (row_width_reg < USED_CAP_V) ? row_width_reg : USED_CAP_V;
        used_m6 = used - LINES_V;
        if (used > LINES_V)
        begin
            cols = (used_m6 > {1'b0, output_size_reg}) ? {1'b0, output_size_reg} : used_m6;
        end
        else
        begin
            cols = '0;
        end
        cols_p6    = {1'b0, cols} + {1'b0, LINES_V};
        frame_rows = {1'b0, output_size_reg} + LINES_V;
        col_inc    = {1'b0, column_count_reg} + 1'b1;
        row_inc    = {1'b0, row_count_reg} + 1'b1;
        in_region  = (cols != '0) && ({1'b0, column_count_reg} < cols_p6)
                     && (row_count_reg < frame_rows);
        produce_now = (row_count_reg >= LINES_V) && (column_count_reg >= LINES_V);
        last_now    = (row_count_reg == frame_rows - 1'b1)
                      && ({1'b0, column_count_reg} == cols_p6 - 1'b1);
    end

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (pix_accept)
        begin
            if (col_inc >= {1'b0, row_width_reg})
            begin
                column_count_next = '0;
                row_count_next = (row_inc >= {1'b0, frame_rows}) ? '0
                                 : row_inc[c2d_pkg::COL_W-1:0];
            end
            else
            begin
                column_count_next = col_inc[c2d_pkg::COL_W-1:0];
            end
        end
    end

    assign tap_issue = (state_reg == ST_RUN) && (step_reg < TAPS_V);
    assign scale_go  = (state_reg == ST_RUN) && (step_reg == SCALE_V);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_accept && in_region)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                step_next  = '0;
                state_next = produce_reg ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_V)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= c2d_pkg::COL_W'(256);
            output_size_reg  <= c2d_pkg::SIZE_W'(250);
            scale_reg        <= c2d_pkg::SCALE_W'(4096);
            column_count_reg <= '0;
            row_count_reg    <= '0;
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            tap_valid_reg    <= 1'b0;
            tap_first_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    c2d_pkg::CFG_ROW_WIDTH:   row_width_reg   <= cfg_data[c2d_pkg::COL_W-1:0];
                    c2d_pkg::CFG_OUTPUT_SIZE: output_size_reg <= cfg_data[c2d_pkg::SIZE_W-1:0];
                    c2d_pkg::CFG_SCALE:       scale_reg       <= cfg_data;
                    default:                  ;
                endcase
            end
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            state_reg        <= state_next;
            step_reg         <= step_next;
            tap_valid_reg    <= tap_issue;
            tap_first_reg    <= tap_issue && (step_reg == '0);
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            pix_reg     <= in_pixel;
            waddr_reg   <= AW'(column_count_reg);
            produce_reg <= produce_now;
            last_reg    <= last_now;
            line_q_reg  <= row_mem[AW'(column_count_reg)];
        end
        if (state_reg == ST_LOAD)
        begin
            row_mem[waddr_reg] <= line_wdata;
        end
        if (coef_write)
        begin
            coef_mem[in_index] <= in_coef;
        end
        if (tap_issue)
        begin
            coef_q_reg   <= coef_mem[step_reg[c2d_pkg::TAP_IDX_W-1:0]];
            win_head_reg <= win_reg[0];
        end
        if (load_out)
        begin
            m_tdata_reg <= mac_res.value;
            m_tuser_reg <= mac_res.sat;
            m_tlast_reg <= last_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < c2d_pkg::LINES; r++)
        begin
            col_in[r] = line_q_reg[r*c2d_pkg::PIX_W +: c2d_pkg::PIX_W];
        end
        col_in[c2d_pkg::LINES] = pix_reg;
        for (int k = 0; k < c2d_pkg::LINES; k++)
        begin
            line_wdata[k*c2d_pkg::PIX_W +: c2d_pkg::PIX_W] = col_in[k+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            for (int r = 0; r < c2d_pkg::KERNEL_W; r++)
            begin
                for (int c = 0; c < c2d_pkg::KERNEL_W - 1; c++)
                begin
                    win_reg[r*c2d_pkg::KERNEL_W + c] <= win_reg[r*c2d_pkg::KERNEL_W + c + 1];
                end
                win_reg[r*c2d_pkg::KERNEL_W + c2d_pkg::KERNEL_W - 1] <= col_in[r];
            end
        end
        else if (tap_issue)
        begin
            for (int t = 0; t < c2d_pkg::TAPS - 1; t++)
            begin
                win_reg[t] <= win_reg[t+1];
            end
            win_reg[c2d_pkg::TAPS-1] <= win_reg[0];
        end
    end

    always_comb
    begin
        mac_ctl.valid = tap_valid_reg || scale_go;
        mac_ctl.first = tap_first_reg;
        mac_ctl.scale = scale_go;
        if (scale_go)
        begin
            mac_a = mac_acc;
            mac_b = scale_reg;
        end
        else
        begin
            mac_a = {{(c2d_pkg::ACC_W-c2d_pkg::PIX_W){win_head_reg[c2d_pkg::PIX_W-1]}},
                     win_head_reg};
            mac_b = coef_q_reg;
        end
    end

    c2d_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc),
        .res   (mac_res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/core/c2d_checker.sv */
// ----------------------------------------------------------------------------
// c2d_checker
// Port-level checks of the 7x7 convolution unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "conv2d_7x7_scaled_unit_macros.svh"

module c2d_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [c2d_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    input  logic                           m_tlast
);

    logic                                coef_beat;
    logic                                at_limit;
    logic [c2d_pkg::OUT_DATA_W+1:0]      out_beat;

    assign coef_beat = s_tvalid && s_tready && (s_tuser == c2d_pkg::MODE_COEF);
    assign at_limit  = (m_tdata == c2d_pkg::RES_MAX) || (m_tdata == c2d_pkg::RES_MIN);
    assign out_beat  = {m_tdata, m_tuser, m_tlast};

    // A coefficient load never starts a computation.
    `C2D_ASSERT_NEXT(a_coef_keeps_ready, coef_beat, s_tready)

    // New results appear only while a computation holds the input side.
    `C2D_ASSERT_SAME(a_result_while_busy, $rose(m_tvalid), !$past(s_tready))

    // A clipped result sits at one end of the range.
    `C2D_ASSERT_SAME(a_sat_at_limit, m_tvalid && m_tuser, at_limit)

    // A stalled result beat stays unchanged until it is taken.
    `C2D_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_beat))

endmodule

bind conv2d_7x7_scaled_unit c2d_checker u_c2d_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
